[hw/rtl/tffsa_pkg.sv]
// ----------------------------------------------------------------------------
// tffsa_pkg
// Shared types and codes for the tagged first-free slot allocator: the
// request and response words, the probe word that walks the cell chain and
// the commit word broadcast back to the cells.
// ----------------------------------------------------------------------------
package tffsa_pkg;

    // Default table depth and the width of a slot number in the probe and commit words
    localparam int DEF_NUM_SLOTS = 8;
    localparam int SLOT_IDX_W    = 6;
    localparam int TAG_W         = 32;
    localparam int RSP_IDX_W     = 3;

    // Request action codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Request word
    typedef struct packed {
        logic                     action;
        logic signed [TAG_W-1:0]  owner_tag;
    } t_req;

    // Response word
    typedef struct packed {
        t_status                  status;
        logic [RSP_IDX_W-1:0]     slot_index;
    } t_rsp;

    // Probe word: request plus the first tag hit and first free slot seen
    typedef struct packed {
        logic                     valid;
        logic                     action;
        logic signed [TAG_W-1:0]  owner_tag;
        logic                     hit;
        logic [SLOT_IDX_W-1:0]    hit_idx;
        logic                     free;
        logic [SLOT_IDX_W-1:0]    free_idx;
    } t_probe;

    // Commit word: at most one slot claimed or released per request
    typedef struct packed {
        logic                     claim;
        logic                     release_slot;
        logic [SLOT_IDX_W-1:0]    idx;
        logic signed [TAG_W-1:0]  owner_tag;
    } t_commit;

endpackage

[hw/rtl/tffsa_cell.sv]
// ----------------------------------------------------------------------------
// tffsa_cell
// One slot of the table. Holds the occupied bit and owner tag, folds its own
// match and free status into the passing probe word and registers it for
// the next cell. Takes a claim or release from the commit broadcast.
// ----------------------------------------------------------------------------
module tffsa_cell
    import tffsa_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_probe  i_probe,
    input  t_commit i_commit,
    output t_probe  o_probe
);

    localparam logic [SLOT_IDX_W-1:0] CELL_IDX = SLOT_IDX_W'(INDEX);

    logic                    r_busy;
    logic signed [TAG_W-1:0] r_owner;
    t_probe                  r_probe;
    t_probe                  n_probe;
    logic                    w_sel;

    // Fold this slot into the probe word, keeping the lowest hit and free
    always_comb begin
        n_probe = i_probe;
        if (r_busy && (r_owner == i_probe.owner_tag) && !i_probe.hit) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = CELL_IDX;
        end
        if (!r_busy && !i_probe.free) begin
            n_probe.free     = 1'b1;
            n_probe.free_idx = CELL_IDX;
        end
    end

    // Advance the probe word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.action    <= n_probe.action;
        r_probe.owner_tag <= n_probe.owner_tag;
        r_probe.hit       <= n_probe.hit;
        r_probe.hit_idx   <= n_probe.hit_idx;
        r_probe.free      <= n_probe.free;
        r_probe.free_idx  <= n_probe.free_idx;
    end

    assign w_sel = (i_commit.idx == CELL_IDX);

    // Claim or release this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_sel && i_commit.claim) begin
            r_busy <= 1'b1;
        end else if (w_sel && i_commit.release_slot) begin
            r_busy <= 1'b0;
        end
    end

    // Record the owner tag on a claim
    always_ff @(posedge i_clk) begin
        if (w_sel && i_commit.claim) begin
            r_owner <= i_commit.owner_tag;
        end
    end

    assign o_probe = r_probe;

endmodule

[hw/rtl/tagged_first_free_slot_allocator.sv]
// Flow: a request is accepted only while busy is low; its probe word walks
//   one cell of the slot chain per cycle and is registered in each cell.
// Throughput: one request at a time; busy stays high until the result is
//   out. Every accepted request gives exactly one result word.
// Reset: synchronous, active low; frees every slot and clears busy and the
//   strobe. Owner tags are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// tagged_first_free_slot_allocator
// Slot table built as a chain of cells. A probe word walks the chain,
// gathering the lowest tag match and lowest free slot; at the end the
// decision is registered as the result and at most one commit is broadcast.
// ----------------------------------------------------------------------------
module tagged_first_free_slot_allocator
    import tffsa_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_probe  w_chain [NUM_SLOTS+1];
    t_probe  w_last;
    t_commit w_commit;
    t_rsp    w_rsp;
    logic    w_accept;
    logic    r_busy;
    logic    n_busy;
    logic    r_valid;
    t_rsp    r_rsp;

    assign w_accept = start && !r_busy;

    // Launch the probe word into the first cell
    always_comb begin
        w_chain[0]           = '0;
        w_chain[0].valid     = w_accept;
        w_chain[0].action    = i_req.action;
        w_chain[0].owner_tag = i_req.owner_tag;
    end

    // Row of slot cells
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        tffsa_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_probe  (w_chain[k]),
            .i_commit (w_commit),
            .o_probe  (w_chain[k+1])
        );
    end

    assign w_last = w_chain[NUM_SLOTS];

    // Decide the result and the commit from the probe leaving the chain
    always_comb begin
        w_rsp              = '0;
        w_rsp.status       = ST_OK;
        w_commit           = '0;
        w_commit.owner_tag = w_last.owner_tag;
        if (w_last.action == ACT_ALLOC) begin
            if (w_last.hit) begin
                w_rsp.status = ST_DUPLICATE;
            end else if (w_last.free) begin
                w_rsp.slot_index = RSP_IDX_W'(w_last.free_idx);
                w_commit.claim   = w_last.valid;
                w_commit.idx     = w_last.free_idx;
            end else begin
                w_rsp.status = ST_FULL;
            end
        end else begin
            if (w_last.hit) begin
                w_rsp.slot_index      = RSP_IDX_W'(w_last.hit_idx);
                w_commit.release_slot = w_last.valid;
                w_commit.idx          = w_last.hit_idx;
            end else begin
                w_rsp.status = ST_NOT_FOUND;
            end
        end
    end

    // Hold busy from accept until the probe leaves the chain
    always_comb begin
        n_busy = r_busy;
        if (w_last.valid) begin
            n_busy = 1'b0;
        end else if (w_accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= w_last.valid;
        end
    end

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_rsp <= w_rsp;
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef NO_ASSERTIONS
    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("busy not raised after accept");

    // A probe leaves the chain only while a request is in flight
    a_probe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |-> r_busy)
        else $error("probe left chain while idle");

    // Results never come back to back
    a_no_b2b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("two result strobes in a row");

    // A refused request reports slot zero
    a_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_rsp.status != ST_OK)) |-> (r_rsp.slot_index == '0))
        else $error("nonzero slot on refused request");

    // Claim and release are never issued together
    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_commit.claim && w_commit.release_slot))
        else $error("claim and release in one cycle");
`endif

endmodule
